// ===== design/bsfns_pkg.sv =====
// Shared types and constants for the bitmap store with find-next-set.
// Holds the command codes and the controller/datapath command and status structs.
// Depends on nothing.
package bsfns_pkg;

  // Default capacity of the store, in bits.
  localparam int CAPACITY_BITS_DEF = 4096;

  // Width of one memory word, in bits, and of a bit offset within it.
  localparam int WORD_BITS = 64;
  localparam int OFF_BITS  = 6;

  // Result field widths.
  localparam int HIT_BITS   = 12;
  localparam int COUNT_BITS = 13;

  // Command codes as carried on the command field.
  typedef enum logic [2:0] {
    CMD_SET        = 3'd0,
    CMD_CLEAR      = 3'd1,
    CMD_FLIP       = 3'd2,
    CMD_GET        = 3'd3,
    CMD_NEXT       = 3'd4,
    CMD_COUNT      = 3'd5,
    CMD_CLEAR_ALL  = 3'd6,
    CMD_FLIP_BLOCK = 3'd7
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch a new command and set up the word range
    logic sweep;   // write zero at the word pointer and advance it
    logic issue;   // issue the next memory read of the word range
    logic proc;    // act on the read word that arrives this cycle
    logic finish;  // copy the working results into the output registers
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;        // command needs no memory access
    logic clear_all;   // command is a clear of the whole store
    logic sweep_last;  // word pointer sits on the last word
    logic scan_done;   // last word processed, or a set bit found
  } dp_status_t;

endpackage

// ===== design/bsfns_ctrl.sv =====
// Controller state machine for the bitmap store with find-next-set.
// Sequences the reset clearing pass, command dispatch, scans and result transfer.
// Depends on bsfns_pkg.
module bsfns_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  bsfns_pkg::dp_status_t status,
  output bsfns_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_SWEEP,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;

  // A new command is taken only while nothing is in progress.
  assign in_ready = (state == ST_IDLE);

  // Decode the state into datapath commands.
  always_comb begin
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.sweep  = (state == ST_INIT) || (state == ST_SWEEP);
    cmd.issue  = (state == ST_SCAN);
    cmd.proc   = (state == ST_SCAN);
    cmd.finish = (state == ST_FINISH) && (!out_valid || out_ready);
  end

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end
      unique case (state)
        ST_INIT: begin
          if (status.sweep_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          if (status.clear_all) begin
            state <= ST_SWEEP;
          end else if (status.skip) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SWEEP: begin
          if (status.sweep_last) begin
            state <= ST_FINISH;
          end
        end
        ST_SCAN: begin
          if (status.scan_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (cmd.finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_INIT;
        end
      endcase
    end
  end

endmodule

// ===== design/bsfns_datapath.sv =====
// Datapath for the bitmap store with find-next-set: word memory, word pointer,
// read-modify-write path, bit search, population count and result registers.
// Depends on bsfns_pkg.
module bsfns_datapath #(
  parameter int CAPACITY_BITS = bsfns_pkg::CAPACITY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bsfns_pkg::ctl_cmd_t                 cmd,
  output bsfns_pkg::dp_status_t               status,
  input  logic [2:0]                          command,
  input  logic [11:0]                         bit_index,
  input  logic [12:0]                         block_length,
  output logic                                bit_value,
  output logic                                found,
  output logic [bsfns_pkg::HIT_BITS-1:0]      hit_position,
  output logic [bsfns_pkg::COUNT_BITS-1:0]    set_count,
  output logic                                range_error
);

  localparam int WB         = bsfns_pkg::WORD_BITS;
  localparam int OB         = bsfns_pkg::OFF_BITS;
  localparam int CB         = bsfns_pkg::COUNT_BITS;
  localparam int STORE_BITS = ((CAPACITY_BITS + 7) / 8) * 8;
  localparam int WORDS      = (STORE_BITS + WB - 1) / WB;
  localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW         = AW + OB;
  localparam int XW         = (PW + 1 > 14) ? PW + 1 : 14;
  localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};

  // Position of the lowest set bit of a word: first the byte, then the bit.
  function automatic logic [OB-1:0] first_set(input logic [WB-1:0] w);
    logic [2:0] byte_sel;
    logic [2:0] bit_sel;
    logic [7:0] b;
    byte_sel = 3'd0;
    bit_sel  = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (w[i*8 +: 8] != 8'd0) begin
        byte_sel = 3'(i);
      end
    end
    b = w[byte_sel*8 +: 8];
    for (int j = 7; j >= 0; j--) begin
      if (b[j]) begin
        bit_sel = 3'(j);
      end
    end
    return {byte_sel, bit_sel};
  endfunction

  // Number of set bits in a word, summed per byte.
  function automatic logic [OB:0] ones_in_word(input logic [WB-1:0] w);
    logic [3:0]  byte_cnt;
    logic [OB:0] total;
    total = '0;
    for (int i = 0; i < 8; i++) begin
      byte_cnt = 4'd0;
      for (int j = 0; j < 8; j++) begin
        byte_cnt = byte_cnt + 4'(w[i*8 + j]);
      end
      total = total + (OB+1)'(byte_cnt);
    end
    return total;
  endfunction

  // Word memory.
  logic [WB-1:0] mem [WORDS];
  logic [WB-1:0] rd_data;

  // Command registers.
  bsfns_pkg::cmd_t cmd_q;
  logic [OB-1:0]   off_lo;
  logic [OB-1:0]   off_hi;
  logic [AW-1:0]   first;
  logic [AW-1:0]   last;
  logic            skip;
  logic            clear_all;

  // Word pointer and read stage.
  logic [AW-1:0] ptr;
  logic          iss_done;
  logic          dv;
  logic [AW-1:0] d_addr;

  // Working results.
  logic                          bitv_w;
  logic                          found_w;
  logic [bsfns_pkg::HIT_BITS-1:0] hit_w;
  logic [CB-1:0]                 acc_w;
  logic                          err_w;

  // Decode of the incoming command for range setup.
  bsfns_pkg::cmd_t in_cmd;
  logic [XW-1:0]   idx_x;
  logic [XW-1:0]   end_x;
  logic [XW-1:0]   endm1_x;
  logic            in_range;
  logic            end_bad;
  logic [AW-1:0]   first_next;
  logic [AW-1:0]   last_next;
  logic            skip_next;
  logic            err_next;

  always_comb begin
    in_cmd     = bsfns_pkg::cmd_t'(command);
    idx_x      = XW'(bit_index);
    end_x      = idx_x + XW'(block_length);
    endm1_x    = end_x - XW'(1);
    in_range   = idx_x < XW'(STORE_BITS);
    end_bad    = end_x > XW'(STORE_BITS);
    first_next = idx_x[PW-1:OB];
    last_next  = idx_x[PW-1:OB];
    skip_next  = 1'b0;
    err_next   = 1'b0;
    case (in_cmd)
      bsfns_pkg::CMD_SET, bsfns_pkg::CMD_FLIP: begin
        skip_next = !in_range;
        err_next  = !in_range;
      end
      bsfns_pkg::CMD_CLEAR, bsfns_pkg::CMD_GET: begin
        skip_next = !in_range;
      end
      bsfns_pkg::CMD_NEXT: begin
        last_next = AW'(WORDS - 1);
        skip_next = !in_range;
      end
      bsfns_pkg::CMD_COUNT, bsfns_pkg::CMD_CLEAR_ALL: begin
        first_next = '0;
        last_next  = AW'(WORDS - 1);
      end
      default: begin
        last_next = endm1_x[PW-1:OB];
        skip_next = (block_length == 13'd0) || end_bad;
        err_next  = (block_length != 13'd0) && end_bad;
      end
    endcase
  end

  // Work on the word that arrives from memory.
  logic [WB-1:0] lo_mask;
  logic [WB-1:0] hi_mask;
  logic [WB-1:0] bit_mask;
  logic [WB-1:0] search_word;
  logic          hit_now;
  logic [PW-1:0] hit_pos;
  logic [CB:0]   acc_sum;
  logic [WB-1:0] mod_word;
  logic          mod_write;

  always_comb begin
    lo_mask     = (d_addr == first) ? ({WB{1'b1}} << off_lo) : {WB{1'b1}};
    hi_mask     = (d_addr == last) ? ({WB{1'b1}} >> (OB'(WB - 1) - off_hi)) : {WB{1'b1}};
    bit_mask    = {{(WB-1){1'b0}}, 1'b1} << off_lo;
    search_word = rd_data & lo_mask;
    hit_now     = (search_word != '0);
    hit_pos     = {d_addr, first_set(search_word)};
    acc_sum     = (CB+1)'(acc_w) + (CB+1)'(ones_in_word(rd_data));
    mod_word    = rd_data;
    mod_write   = 1'b0;
    case (cmd_q)
      bsfns_pkg::CMD_SET: begin
        mod_word  = rd_data | bit_mask;
        mod_write = 1'b1;
      end
      bsfns_pkg::CMD_CLEAR: begin
        mod_word  = rd_data & ~bit_mask;
        mod_write = 1'b1;
      end
      bsfns_pkg::CMD_FLIP: begin
        mod_word  = rd_data ^ bit_mask;
        mod_write = 1'b1;
      end
      bsfns_pkg::CMD_FLIP_BLOCK: begin
        mod_word  = rd_data ^ (lo_mask & hi_mask);
        mod_write = 1'b1;
      end
      default: begin
        mod_write = 1'b0;
      end
    endcase
  end

  // Memory write port: clearing sweep or write-back of the modified word.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [WB-1:0] wr_data;
  logic          rd_en;

  assign wr_en   = cmd.sweep || (cmd.proc && dv && mod_write);
  assign wr_addr = cmd.sweep ? ptr : d_addr;
  assign wr_data = cmd.sweep ? '0 : mod_word;
  assign rd_en   = cmd.issue && !iss_done;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[ptr];
    end
  end

  // Status back to the controller.
  always_comb begin
    status.skip       = skip;
    status.clear_all  = clear_all;
    status.sweep_last = (ptr == last);
    status.scan_done  = cmd.proc && dv &&
                        ((d_addr == last) || ((cmd_q == bsfns_pkg::CMD_NEXT) && hit_now));
  end

  // Pointer, read stage and command registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      last      <= AW'(WORDS - 1);
      iss_done  <= 1'b0;
      dv        <= 1'b0;
      skip      <= 1'b0;
      clear_all <= 1'b0;
    end else if (cmd.load) begin
      ptr       <= first_next;
      last      <= last_next;
      iss_done  <= 1'b0;
      dv        <= 1'b0;
      skip      <= skip_next;
      clear_all <= (in_cmd == bsfns_pkg::CMD_CLEAR_ALL);
    end else begin
      dv <= rd_en;
      if (cmd.sweep) begin
        ptr <= ptr + AW'(1);
      end else if (rd_en) begin
        ptr <= ptr + AW'(1);
        if (ptr == last) begin
          iss_done <= 1'b1;
        end
      end
    end
  end

  // Command payload and working results.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      d_addr <= ptr;
    end
    if (cmd.load) begin
      cmd_q   <= in_cmd;
      first   <= first_next;
      off_lo  <= bit_index[OB-1:0];
      off_hi  <= endm1_x[OB-1:0];
      err_w   <= err_next;
      bitv_w  <= 1'b0;
      found_w <= 1'b0;
      hit_w   <= '0;
      acc_w   <= '0;
    end else if (cmd.proc && dv) begin
      case (cmd_q)
        bsfns_pkg::CMD_GET: begin
          bitv_w <= rd_data[off_lo];
        end
        bsfns_pkg::CMD_NEXT: begin
          if (hit_now) begin
            found_w <= 1'b1;
            hit_w   <= bsfns_pkg::HIT_BITS'(hit_pos);
          end
        end
        bsfns_pkg::CMD_COUNT: begin
          acc_w <= (acc_sum > (CB+1)'(COUNT_MAX)) ? COUNT_MAX : acc_sum[CB-1:0];
        end
        default: begin
          acc_w <= acc_w;
        end
      endcase
    end
  end

  // Output registers, loaded when the result transfer is set up.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      bit_value    <= bitv_w;
      found        <= found_w;
      hit_position <= hit_w;
      set_count    <= acc_w;
      range_error  <= err_w;
    end
  end

endmodule

// ===== design/bitmap_store_find_next_set_core.sv =====
// Top level of the bitmap store with find-next-set and population count.
// Joins the controller and the datapath; depends on bsfns_pkg, bsfns_ctrl, bsfns_datapath.
//
//   Channel  Handshake            Payload
//   -------  -------------------  -----------------------------------------------
//   in       in_valid / in_ready  command, bit_index, block_length
//   out      out_valid/ out_ready bit_value, found, hit_position, set_count,
//                                 range_error
//
// The store is a memory of 64-bit words, W = ceil(capacity / 64) words (64 by default),
// read and written one word per cycle. Set, clear, flip and get touch one word; count
// reads all W words, next set reads from the word of bit_index on up to the first set
// bit or the last word, flip block its word span, clear all writes all W words, and skipped
// commands none. After reset a clearing pass writes every word once with in_ready low.
// A new command is taken while an earlier result still waits for its transfer out;
// a finished command waits only if the output register is still full.
module bitmap_store_find_next_set_core #(
  parameter int CAPACITY_BITS = bsfns_pkg::CAPACITY_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       command,
  input  logic [11:0]                      bit_index,
  input  logic [12:0]                      block_length,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             bit_value,
  output logic                             found,
  output logic [bsfns_pkg::HIT_BITS-1:0]   hit_position,
  output logic [bsfns_pkg::COUNT_BITS-1:0] set_count,
  output logic                             range_error
);

  bsfns_pkg::ctl_cmd_t   cmd;
  bsfns_pkg::dp_status_t status;

  // Sequencing of each command.
  bsfns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Store, scan logic and result registers.
  bsfns_datapath #(
    .CAPACITY_BITS (CAPACITY_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .command      (command),
    .bit_index    (bit_index),
    .block_length (block_length),
    .bit_value    (bit_value),
    .found        (found),
    .hit_position (hit_position),
    .set_count    (set_count),
    .range_error  (range_error)
  );

endmodule
